### hw/rtl/plu_pkg.sv
// Shared types, constants and helpers for the Phong lighting unit.
// No dependencies; every other RTL file but plu_intf imports this package.
`default_nettype none

package plu_pkg;

  localparam int unsigned FracBits = 14;
  localparam logic [15:0] OneQ14   = 16'd16384;
  localparam int unsigned DirRegs  = 2;
  localparam int unsigned ExpW     = 4;
  localparam int unsigned PowSteps = (1 << ExpW) - 1;
  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [2:0] {
    REG_AMBIENT  = 3'd0,
    REG_DIFFUSE  = 3'd1,
    REG_SPECULAR = 3'd2,
    REG_EXPONENT = 3'd3,
    REG_LIGHT0   = 3'd4,
    REG_LIGHT1   = 3'd5,
    REG_ENABLES  = 3'd6
  } reg_idx_t;

  // index 0 = x / red, 1 = y / green, 2 = z / blue
  typedef logic [2:0][15:0] vec3_t;
  typedef logic [2:0][7:0]  color_t;

  typedef struct packed {
    logic [15:0]               ambient_gain;
    logic [15:0]               diffuse_gain;
    logic [15:0]               specular_gain;
    logic [ExpW-1:0]           spec_exp;
    logic [DirRegs-1:0][47:0]  light_dir;
    logic [DirRegs-1:0]        light_en;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    ambient_gain:  16'd16384,
    diffuse_gain:  16'd4915,
    specular_gain: 16'd11469,
    spec_exp:      4'd3,
    light_dir:     {48'h0000_0000_4000, 48'h4000_0000_0000},
    light_en:      2'b11
  };

  function automatic logic [15:0] sat16(input logic [19:0] v);
    return (|v[19:16]) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/plu_intf.sv
// Valid/ready channel interfaces for shading items and shaded results.
// Stand-alone; no package dependency.
`default_nettype none

interface plu_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [7:0]         base_red;
  logic [7:0]         base_green;
  logic [7:0]         base_blue;

  modport source (output valid, normal_x, normal_y, normal_z,
                  base_red, base_green, base_blue, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z,
                  base_red, base_green, base_blue, output ready);
endinterface

interface plu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] shaded_red;
  logic [7:0] shaded_green;
  logic [7:0] shaded_blue;

  modport source (output valid, shaded_red, shaded_green, shaded_blue, input ready);
  modport sink   (input valid, shaded_red, shaded_green, shaded_blue, output ready);
endinterface

`default_nettype wire

### hw/rtl/plu_cfg_regs.sv
// APB register file holding gains, exponent, light directions and enables.
// Depends on plu_pkg.
`default_nettype none

module plu_cfg_regs
  import plu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CfgAddrW-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_AMBIENT:  cfg_r.ambient_gain  <= pwdata[15:0];
        REG_DIFFUSE:  cfg_r.diffuse_gain  <= pwdata[15:0];
        REG_SPECULAR: cfg_r.specular_gain <= pwdata[15:0];
        REG_EXPONENT: cfg_r.spec_exp      <= pwdata[ExpW-1:0];
        REG_LIGHT0:   cfg_r.light_dir[0]  <= pwdata[47:0];
        REG_LIGHT1:   cfg_r.light_dir[1]  <= pwdata[47:0];
        REG_ENABLES:  cfg_r.light_en      <= pwdata[DirRegs-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AMBIENT:  prdata = CfgDataW'(cfg_r.ambient_gain);
      REG_DIFFUSE:  prdata = CfgDataW'(cfg_r.diffuse_gain);
      REG_SPECULAR: prdata = CfgDataW'(cfg_r.specular_gain);
      REG_EXPONENT: prdata = CfgDataW'(cfg_r.spec_exp);
      REG_LIGHT0:   prdata = CfgDataW'(cfg_r.light_dir[0]);
      REG_LIGHT1:   prdata = CfgDataW'(cfg_r.light_dir[1]);
      REG_ENABLES:  prdata = CfgDataW'(cfg_r.light_en);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/plu_dot.sv
// Two-stage dot product unit: light and half vector against the normal, per light.
// Stage A registers the products, stage B sums, clamps and saturates. Depends on plu_pkg.
`default_nettype none

module plu_dot
  import plu_pkg::*;
#(
  parameter int unsigned NL = 2
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  vec3_t               normal,
  input  color_t              base,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NL-1:0][15:0] dd,
  output logic [NL-1:0][15:0] dh,
  output color_t              out_base
);

  logic               va_r, vb_r, en_a, en_b;
  logic signed [31:0] pl_r   [NL][3];
  logic signed [31:0] ph_r   [NL][3];
  logic signed [31:0] pl_nxt [NL][3];
  logic signed [31:0] ph_nxt [NL][3];
  color_t             base_a_r, base_b_r;
  logic [NL-1:0][15:0] dd_r, dh_r, dd_nxt, dh_nxt;

  function automatic logic [15:0] clamp_dot(input logic signed [33:0] s);
    logic signed [33:0] q;
    q = s >>> FracBits;
    if (s <= 34'sd0) return '0;
    return sat16(q[19:0]);
  endfunction

  assign en_b     = !vb_r || out_ready;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;

  always_comb begin
    logic signed [15:0] l, h;
    logic signed [16:0] zsum;
    for (int i = 0; i < NL; i++) begin
      for (int c = 0; c < 3; c++) begin
        l = $signed(cfg.light_dir[i][16*c +: 16]);
        zsum = 17'(l) + 17'sd16384;
        if (c == 2) h = zsum[16:1];
        else        h = l >>> 1;
        pl_nxt[i][c] = l * $signed(normal[c]);
        ph_nxt[i][c] = h * $signed(normal[c]);
      end
    end
  end

  always_comb begin
    logic signed [33:0] sl, sh;
    for (int i = 0; i < NL; i++) begin
      sl = 34'(pl_r[i][0]) + 34'(pl_r[i][1]) + 34'(pl_r[i][2]);
      sh = 34'(ph_r[i][0]) + 34'(ph_r[i][1]) + 34'(ph_r[i][2]);
      dd_nxt[i] = clamp_dot(sl);
      dh_nxt[i] = clamp_dot(sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      pl_r     <= pl_nxt;
      ph_r     <= ph_nxt;
      base_a_r <= base;
    end
    if (en_b) begin
      dd_r     <= dd_nxt;
      dh_r     <= dh_nxt;
      base_b_r <= base_a_r;
    end
  end

  assign out_valid = vb_r;
  assign dd        = dd_r;
  assign dh        = dh_r;
  assign out_base  = base_b_r;

endmodule

`default_nettype wire

### hw/rtl/plu_pow.sv
// Specular power pipeline: one Q2.14 multiply-and-saturate step per stage.
// Steps at or beyond the exponent pass the value through. Depends on plu_pkg.
`default_nettype none

module plu_pow
  import plu_pkg::*;
#(
  parameter int unsigned NL = 2
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NL-1:0][15:0] dd,
  input  logic [NL-1:0][15:0] dh,
  input  color_t              base,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NL-1:0][15:0] out_dd,
  output logic [NL-1:0][15:0] out_pw,
  output color_t              out_base
);

  logic [PowSteps-1:0]  v_r, v_in;
  logic [PowSteps:0]    en;
  logic [NL-1:0][15:0]  pw_r   [PowSteps];
  logic [NL-1:0][15:0]  dd_r   [PowSteps];
  logic [NL-1:0][15:0]  dh_r   [PowSteps];
  color_t               base_r [PowSteps];
  logic [NL-1:0][15:0]  pw_in  [PowSteps];
  logic [NL-1:0][15:0]  pw_nxt [PowSteps];
  logic [NL-1:0][15:0]  dd_in  [PowSteps];
  logic [NL-1:0][15:0]  dh_in  [PowSteps];
  color_t               base_in[PowSteps];

  assign en[PowSteps] = out_ready;
  assign in_ready     = en[0];

  for (genvar k = 0; k < PowSteps; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  always_comb begin
    logic [31:0] prod;
    for (int k = 0; k < PowSteps; k++) begin
      if (k == 0) begin
        v_in[k]    = in_valid;
        pw_in[k]   = {NL{OneQ14}};
        dd_in[k]   = dd;
        dh_in[k]   = dh;
        base_in[k] = base;
      end else begin
        v_in[k]    = v_r[k-1];
        pw_in[k]   = pw_r[k-1];
        dd_in[k]   = dd_r[k-1];
        dh_in[k]   = dh_r[k-1];
        base_in[k] = base_r[k-1];
      end
      for (int i = 0; i < NL; i++) begin
        prod = 32'(pw_in[k][i]) * 32'(dh_in[k][i]);
        if (ExpW'(k) < cfg.spec_exp) pw_nxt[k][i] = sat16(20'(prod >> FracBits));
        else                         pw_nxt[k][i] = pw_in[k][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < PowSteps; k++) begin
        if (en[k]) v_r[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PowSteps; k++) begin
      if (en[k]) begin
        pw_r[k]   <= pw_nxt[k];
        dd_r[k]   <= dd_in[k];
        dh_r[k]   <= dh_in[k];
        base_r[k] <= base_in[k];
      end
    end
  end

  assign out_valid = v_r[PowSteps-1];
  assign out_dd    = dd_r[PowSteps-1];
  assign out_pw    = pw_r[PowSteps-1];
  assign out_base  = base_r[PowSteps-1];

endmodule

`default_nettype wire

### hw/rtl/plu_shade.sv
// Shading back end: gain multiplies, per-light coefficient sum, channel
// multiply-accumulate and saturation into the output register. Depends on plu_pkg.
`default_nettype none

module plu_shade
  import plu_pkg::*;
#(
  parameter int unsigned NL = 2
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NL-1:0][15:0] dd,
  input  logic [NL-1:0][15:0] pw,
  input  color_t              base,
  output logic                out_valid,
  input  logic                out_ready,
  output color_t              rgb
);

  localparam int unsigned CoefW = 19 + $clog2(NL);
  localparam int unsigned AccW  = CoefW + 9;
  localparam int unsigned HiW   = AccW - FracBits;

  logic                vc_r, vd_r, ve_r, en_c, en_d, en_e;
  logic [31:0]         kdp_r [NL];
  logic [31:0]         ksp_r [NL];
  logic [31:0]         kdp_nxt [NL];
  logic [31:0]         ksp_nxt [NL];
  logic [2:0][23:0]    amb_c_r, amb_d_r, amb_nxt;
  color_t              base_c_r, base_d_r, rgb_r, rgb_nxt;
  logic [CoefW-1:0]    coef_r, coef_nxt;

  assign en_e     = !ve_r || out_ready;
  assign en_d     = !vd_r || en_e;
  assign en_c     = !vc_r || en_d;
  assign in_ready = en_c;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      kdp_nxt[i] = 32'(cfg.diffuse_gain) * 32'(dd[i]);
      ksp_nxt[i] = 32'(cfg.specular_gain) * 32'(pw[i]);
    end
    for (int c = 0; c < 3; c++) begin
      amb_nxt[c] = 24'(cfg.ambient_gain) * 24'(base[c]);
    end
  end

  always_comb begin
    coef_nxt = '0;
    for (int i = 0; i < NL; i++) begin
      if (cfg.light_en[i]) begin
        coef_nxt = coef_nxt + CoefW'(kdp_r[i][31:FracBits]) + CoefW'(ksp_r[i][31:FracBits]);
      end
    end
  end

  always_comb begin
    logic [AccW-1:0] acc;
    logic [HiW-1:0]  hi;
    for (int c = 0; c < 3; c++) begin
      acc = AccW'(amb_d_r[c]) + AccW'(coef_r) * AccW'(base_d_r[c]);
      hi  = acc[AccW-1:FracBits];
      rgb_nxt[c] = (|hi[HiW-1:8]) ? 8'hFF : hi[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (en_c) vc_r <= in_valid;
      if (en_d) vd_r <= vc_r;
      if (en_e) ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      kdp_r    <= kdp_nxt;
      ksp_r    <= ksp_nxt;
      amb_c_r  <= amb_nxt;
      base_c_r <= base;
    end
    if (en_d) begin
      coef_r   <= coef_nxt;
      amb_d_r  <= amb_c_r;
      base_d_r <= base_c_r;
    end
    if (en_e) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign out_valid = ve_r;
  assign rgb       = rgb_r;

endmodule

`default_nettype wire

### hw/rtl/phong_lighting_unit_core.sv
// Phong lighting unit top level: register file, dot, power and shading pipelines.
// Depends on plu_pkg, plu_intf, plu_cfg_regs, plu_dot, plu_pow, plu_shade.
//
//   port      dir   kind            payload
//   in_bus    in    valid/ready     normal_x/y/z (s16), base_red/green/blue (u8)
//   out_bus   out   valid/ready     shaded_red/green/blue (u8)
//   psel..    in    APB write/read  7 registers at 8*i, 64-bit data
//
// One item per cycle while out_bus is not stalled; 2 dot stages, 15 power stages (one per
// possible exponent step) and 3 shading stages ending in the output register.
// Every stage carries its own valid bit and advances when it is empty or the next
// one advances, so a stalled output holds data without loss while bubbles fill.
// rst_n is synchronous: it clears the valid bits and loads register defaults.
`default_nettype none

module phong_lighting_unit_core
  import plu_pkg::*;
#(
  parameter int unsigned LIGHT_CNT = 2
)
(
  input  logic                clk,
  input  logic                rst_n,
  plu_in_if.sink              in_bus,
  plu_out_if.source           out_bus,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned NL = (LIGHT_CNT < DirRegs) ? LIGHT_CNT : DirRegs;

  cfg_t                cfg;
  vec3_t               normal;
  color_t              base_in, base_dp, base_ps, rgb;
  logic                dp_valid, dp_ready, ps_valid, ps_ready;
  logic [NL-1:0][15:0] dd_dp, dh_dp, dd_ps, pw_ps;

  assign normal  = {in_bus.normal_z, in_bus.normal_y, in_bus.normal_x};
  assign base_in = {in_bus.base_blue, in_bus.base_green, in_bus.base_red};

  plu_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  plu_dot #(.NL(NL)) u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .normal    (normal),
    .base      (base_in),
    .out_valid (dp_valid),
    .out_ready (dp_ready),
    .dd        (dd_dp),
    .dh        (dh_dp),
    .out_base  (base_dp)
  );

  plu_pow #(.NL(NL)) u_pow (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (dp_valid),
    .in_ready  (dp_ready),
    .dd        (dd_dp),
    .dh        (dh_dp),
    .base      (base_dp),
    .out_valid (ps_valid),
    .out_ready (ps_ready),
    .out_dd    (dd_ps),
    .out_pw    (pw_ps),
    .out_base  (base_ps)
  );

  plu_shade #(.NL(NL)) u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (ps_valid),
    .in_ready  (ps_ready),
    .dd        (dd_ps),
    .pw        (pw_ps),
    .base      (base_ps),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .rgb       (rgb)
  );

  assign out_bus.shaded_red   = rgb[0];
  assign out_bus.shaded_green = rgb[1];
  assign out_bus.shaded_blue  = rgb[2];

endmodule

`default_nettype wire
